// ===== rtl/neighbor_community_accumulator_defines.svh =====
// assertion macros for the accumulator rtl, included by the back end
`ifndef NEIGHBOR_COMMUNITY_ACCUMULATOR_DEFINES_SVH
`define NEIGHBOR_COMMUNITY_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nca assertion failed");

// next-cycle implication, checked outside reset
`define NCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nca assertion failed");

`endif

// ===== rtl/nca_pkg.sv =====
// types and constants of the neighbor community accumulator
package nca_pkg;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_ARC   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  node_id;
        logic [9:0]  neighbor_id;
        logic [9:0]  community_id;
        logic [31:0] arc_weight;
        logic [9:0]  list_position;
    } t_nca_in;

    typedef struct packed {
        logic [9:0]  out_community;
        logic [31:0] out_weight;
        logic [9:0]  out_position;
        logic [10:0] community_count;
        logic        newly_found;
        logic        arc_ignored;
        logic        read_valid;
    } t_nca_out;

    typedef enum logic [2:0] {
        K_BEGIN,
        K_ARC,
        K_READ,
        K_SELF,
        K_NULL
    } t_nca_kind;

    typedef struct packed {
        t_nca_kind   kind;
        logic        bad;
        logic [9:0]  comm;
        logic [31:0] add;
        logic [9:0]  lpos;
    } t_nca_cmd;

endpackage

// ===== rtl/nca_front.sv =====
// front end: accepts words, tracks the current node, classifies into commands
module nca_front #(
    parameter int MAX_COMMUNITIES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  nca_pkg::t_nca_in i_in_word,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    input  logic             i_full,
    output logic             o_push,
    output nca_pkg::t_nca_cmd o_cmd
);
    import nca_pkg::*;

    logic [9:0] r_node;
    logic       r_weighted;
    logic       comm_bad;

    assign o_push   = i_in_valid && !i_full;
    assign comm_bad = 32'(i_in_word.community_id) >= 32'(MAX_COMMUNITIES);

    always_comb begin
        o_cmd.bad  = comm_bad;
        o_cmd.comm = i_in_word.community_id;
        o_cmd.add  = r_weighted ? i_in_word.arc_weight : ONE_Q16;
        o_cmd.lpos = i_in_word.list_position;
        case (i_in_word.op)
            OP_BEGIN: o_cmd.kind = K_BEGIN;
            OP_ARC: begin
                if (i_in_word.neighbor_id == r_node) begin
                    o_cmd.kind = K_SELF;
                end else if (comm_bad) begin
                    o_cmd.kind = K_NULL;
                end else begin
                    o_cmd.kind = K_ARC;
                end
            end
            OP_READ: o_cmd.kind = K_READ;
            default: o_cmd.kind = K_NULL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node     <= '0;
            r_weighted <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_weighted <= i_cfg_data;
            end
            if (o_push && i_in_word.op == OP_BEGIN) begin
                r_node <= i_in_word.node_id;
            end
        end
    end

endmodule

// ===== rtl/nca_fifo.sv =====
// short command queue between front and back
module nca_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nca_pkg::t_nca_cmd i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_avail,
    output nca_pkg::t_nca_cmd o_head
);
    import nca_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_nca_cmd          r_slot [FIFO_DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [PW:0]       r_fill;

    assign o_full  = r_fill == (PW+1)'(FIFO_DEPTH);
    assign o_avail = r_fill != '0;
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_fill <= r_fill + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

// ===== rtl/nca_back.sv =====
// back end: sequencer over the community stores and the result register
`include "neighbor_community_accumulator_defines.svh"
module nca_back #(
    parameter int MAX_COMMUNITIES = 1024,
    parameter int WEIGHT_BITS     = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  nca_pkg::t_nca_cmd i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output nca_pkg::t_nca_out o_out_word
);
    import nca_pkg::*;

    localparam int CW   = $clog2(MAX_COMMUNITIES);
    localparam int CNTW = $clog2(MAX_COMMUNITIES + 1);
    localparam int SW   = ((WEIGHT_BITS > 32) ? WEIGHT_BITS : 32) + 1;
    localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_EXEC, S_CLR_RD, S_CLR_WR, S_BEG_SET,
        S_ARC_UPD, S_RD_WT, S_RD_OUT
    } t_state;

    function automatic logic [WEIGHT_BITS-1:0] f_sat(input logic [WEIGHT_BITS-1:0] a,
                                                     input logic [31:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        return (s > SW'(WMAX)) ? WMAX : WEIGHT_BITS'(s);
    endfunction

    // stores
    logic [WEIGHT_BITS-1:0] mem_wt    [MAX_COMMUNITIES];
    logic                   mem_mark  [MAX_COMMUNITIES];
    logic [CW-1:0]          mem_slot  [MAX_COMMUNITIES];
    logic [CW-1:0]          mem_order [MAX_COMMUNITIES];

    logic                   wt_we, mark_we, slot_we, ord_we;
    logic [CW-1:0]          wt_wa, mark_wa, slot_wa, ord_wa;
    logic [WEIGHT_BITS-1:0] wt_wd;
    logic                   mark_wd;
    logic [CW-1:0]          slot_wd, ord_wd;
    logic [CW-1:0]          wt_ra, mark_ra, slot_ra, ord_ra;
    logic [WEIGHT_BITS-1:0] r_rd_wt;
    logic                   r_rd_mark;
    logic [CW-1:0]          r_rd_slot, r_rd_ord;

    t_state    r_state, n_state;
    t_nca_cmd  r_cmd, n_cmd;
    logic [CNTW-1:0] r_idx, n_idx;
    logic [CNTW-1:0] r_count, n_count;
    logic      r_out_valid, n_out_valid;
    t_nca_out  r_out, n_out;

    logic [CW-1:0]          cmd_comm;
    logic [WEIGHT_BITS-1:0] new_w;

    assign cmd_comm    = CW'(r_cmd.comm);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (wt_we) mem_wt[wt_wa] <= wt_wd;
        r_rd_wt <= mem_wt[wt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (mark_we) mem_mark[mark_wa] <= mark_wd;
        r_rd_mark <= mem_mark[mark_ra];
    end
    always_ff @(posedge i_clk) begin
        if (slot_we) mem_slot[slot_wa] <= slot_wd;
        r_rd_slot <= mem_slot[slot_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ord_we) mem_order[ord_wa] <= ord_wd;
        r_rd_ord <= mem_order[ord_ra];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        wt_we = 1'b0; mark_we = 1'b0; slot_we = 1'b0; ord_we = 1'b0;
        wt_wa = cmd_comm; mark_wa = cmd_comm; slot_wa = cmd_comm; ord_wa = '0;
        wt_wd = '0; mark_wd = 1'b0; slot_wd = '0; ord_wd = cmd_comm;
        wt_ra = cmd_comm; mark_ra = cmd_comm; slot_ra = cmd_comm;
        ord_ra = CW'(r_cmd.lpos);
        new_w = f_sat(r_rd_mark ? r_rd_wt : '0, r_cmd.add);
        case (r_state)
            S_INIT: begin
                mark_we = 1'b1;
                mark_wa = r_idx[CW-1:0];
                n_idx   = r_idx + 1'b1;
                if (r_idx == CNTW'(MAX_COMMUNITIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_avail && (!r_out_valid || !i_out_stall)) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out = '0;
                case (r_cmd.kind)
                    K_BEGIN: begin
                        n_idx   = '0;
                        n_state = (r_count == '0) ? S_BEG_SET : S_CLR_RD;
                    end
                    K_ARC: n_state = S_ARC_UPD;
                    K_READ: begin
                        if (CNTW'(r_cmd.lpos) < r_count && 32'(r_cmd.lpos) < r_count) begin
                            n_state = S_RD_WT;
                        end else begin
                            n_out.community_count = 11'(r_count);
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    K_SELF: begin
                        n_out.arc_ignored     = 1'b1;
                        n_out.community_count = 11'(r_count);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        n_out.community_count = 11'(r_count);
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_CLR_RD: begin
                ord_ra  = r_idx[CW-1:0];
                n_state = S_CLR_WR;
            end
            S_CLR_WR: begin
                mark_we = 1'b1;
                mark_wa = r_rd_ord;
                mark_wd = 1'b0;
                n_idx   = r_idx + 1'b1;
                n_state = (r_idx + 1'b1 == r_count) ? S_BEG_SET : S_CLR_RD;
            end
            S_BEG_SET: begin
                n_out = '0;
                if (r_cmd.bad) begin
                    n_count = '0;
                end else begin
                    mark_we = 1'b1; mark_wd = 1'b1;
                    wt_we   = 1'b1;
                    slot_we = 1'b1;
                    ord_we  = 1'b1;
                    n_count = CNTW'(1);
                    n_out.out_community = r_cmd.comm;
                    n_out.newly_found   = 1'b1;
                end
                n_out.community_count = 11'(n_count);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_ARC_UPD: begin
                n_out = '0;
                if (r_rd_mark) begin
                    wt_we = 1'b1;
                    wt_wd = new_w;
                    n_out.out_community = r_cmd.comm;
                    n_out.out_weight    = 32'(new_w);
                    n_out.out_position  = 10'(r_rd_slot);
                end else if (r_count < CNTW'(MAX_COMMUNITIES)) begin
                    mark_we = 1'b1; mark_wd = 1'b1;
                    wt_we   = 1'b1; wt_wd = new_w;
                    slot_we = 1'b1; slot_wd = r_count[CW-1:0];
                    ord_we  = 1'b1; ord_wa = r_count[CW-1:0];
                    n_count = r_count + 1'b1;
                    n_out.out_community = r_cmd.comm;
                    n_out.out_weight    = 32'(new_w);
                    n_out.out_position  = 10'(r_count);
                    n_out.newly_found   = 1'b1;
                end
                n_out.community_count = 11'(n_count);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_RD_WT: begin
                wt_ra   = r_rd_ord;
                n_idx   = CNTW'(r_rd_ord);
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                n_out = '0;
                n_out.out_community   = 10'(r_idx);
                n_out.out_weight      = 32'(r_rd_wt);
                n_out.out_position    = r_cmd.lpos;
                n_out.community_count = 11'(r_count);
                n_out.read_valid      = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    `NCA_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNTW'(MAX_COMMUNITIES))
    `NCA_ASSERT_NOW(a_pop_free, o_pop, !r_out_valid || !i_out_stall)
    `NCA_ASSERT_NOW(a_flags_excl, r_out_valid, !(r_out.newly_found && r_out.arc_ignored))
    `NCA_ASSERT_NEXT(a_init_no_pop, r_state == S_INIT, !$past(o_pop))

endmodule

// ===== rtl/neighbor_community_accumulator.sv =====
// top level: arc weight accumulation per neighboring community
// each accepted word goes through the command queue to the back end and yields one result;
// a valid arc does one store read-modify-write, a begin first clears the listed marks
// the back end takes a new command only when the last is done and the output is not stalled
// reset: synchronous active low; then a clearing pass over all MAX_COMMUNITIES marks,
// during which the queue fills but no command runs
module neighbor_community_accumulator #(
    parameter int MAX_COMMUNITIES = 1024,
    parameter int WEIGHT_BITS     = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nca_pkg::t_nca_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output nca_pkg::t_nca_out o_out_word,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data
);
    import nca_pkg::*;

    // front to queue
    logic     push;
    t_nca_cmd cmd;
    logic     full;
    // queue to back
    logic     avail;
    logic     pop;
    t_nca_cmd head;

    // input stalls only when the command queue is full
    assign o_in_stall = full;

    // classification and self loop detection against the last begin node
    nca_front #(
        .MAX_COMMUNITIES(MAX_COMMUNITIES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_word (i_in_word),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (cmd)
    );

    // decouples the front from long begin walks in the back
    nca_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_full (full),
        .o_avail(avail),
        .o_head (head)
    );

    // stores, list walk and saturating accumulation
    nca_back #(
        .MAX_COMMUNITIES(MAX_COMMUNITIES),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (avail),
        .i_head     (head),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the neighbor community accumulator
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nca_pkg::*;

    localparam int  COMM_SLOTS  = 1024;
    localparam int  CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] OP_IDLE = 2'd3;   // opcode three does nothing

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     o_in_stall;
    t_nca_in  in_word = '0;
    logic     o_out_valid;
    logic     out_stall = 1'b0;
    t_nca_out o_out_word;
    logic     cfg_we = 1'b0;
    logic     cfg_data = 1'b0;

    neighbor_community_accumulator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mirror of the block state, used to work out each expected result
    logic [31:0] comm_weight [COMM_SLOTS];
    bit          comm_seen   [COMM_SLOTS];
    logic [9:0]  comm_slot   [COMM_SLOTS];
    logic [9:0]  found_order [COMM_SLOTS];
    int          found_total = 0;
    logic [9:0]  node_now = '0;
    bit          weighted_q = 1'b0;

    t_nca_in  pending_words [$];
    t_nca_out expected_words [$];
    int       error_count = 0;
    bit       calm = 1'b0;       // no idling on either side while set
    bit       hold_req = 1'b0;   // ask the receiver for one long hold-off
    int       cycle_count = 0;

    // append one word to the stimulus queue
    task automatic enqueue(input t_nca_in w);
        pending_words = {pending_words, w};
    endtask

    // work out the result of one accepted word and update the mirror state
    task automatic accumulate(input t_nca_in w);
        t_nca_out    r;
        logic [32:0] sum;
        logic [31:0] addend;
        r = '0;
        case (w.op)
            OP_BEGIN: begin
                for (int i = 0; i < found_total; i++) comm_seen[found_order[i]] = 1'b0;
                node_now = w.node_id;
                found_order[0] = w.community_id;
                comm_seen[w.community_id] = 1'b1;
                comm_slot[w.community_id] = '0;
                comm_weight[w.community_id] = '0;
                found_total = 1;
                r.out_community = w.community_id;
                r.newly_found = 1'b1;
            end
            OP_ARC: begin
                if (w.neighbor_id == node_now) begin
                    r.arc_ignored = 1'b1;
                end else if (!comm_seen[w.community_id] && found_total >= COMM_SLOTS) begin
                    r = '0;
                end else begin
                    if (!comm_seen[w.community_id]) begin
                        comm_seen[w.community_id] = 1'b1;
                        comm_weight[w.community_id] = '0;
                        comm_slot[w.community_id] = found_total[9:0];
                        found_order[found_total] = w.community_id;
                        found_total++;
                        r.newly_found = 1'b1;
                    end
                    addend = weighted_q ? w.arc_weight : ONE_Q16;
                    sum = {1'b0, comm_weight[w.community_id]} + {1'b0, addend};
                    comm_weight[w.community_id] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    r.out_community = w.community_id;
                    r.out_weight = comm_weight[w.community_id];
                    r.out_position = comm_slot[w.community_id];
                end
            end
            OP_READ: begin
                if (w.list_position < found_total) begin
                    r.out_community = found_order[w.list_position];
                    r.out_weight = comm_weight[found_order[w.list_position]];
                    r.out_position = w.list_position;
                    r.read_valid = 1'b1;
                end
            end
            default: r = '0;
        endcase
        r.community_count = found_total[10:0];
        expected_words = {expected_words, r};
    endtask

    function automatic int next_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver: accept check first, then present the next word
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) accumulate(in_word);
            if (!in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap--;
                end else if (pending_words.size() > 0) begin
                    in_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    send_gap = next_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off on request so the input backs up
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            stall_cnt = 400;
            out_stall <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            stall_cnt = next_gap();
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_nca_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %p", $realtime, o_out_word);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_out_word !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, o_out_word);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** neighbor_community_accumulator: FAILED **");
            $finish;
        end
    end

    function automatic t_nca_in make_word(input logic [1:0] op, input logic [9:0] node,
                                          input logic [9:0] neigh, input logic [9:0] comm,
                                          input logic [31:0] wt, input logic [9:0] lpos);
        t_nca_in w;
        w.op = op;
        w.node_id = node;
        w.neighbor_id = neigh;
        w.community_id = comm;
        w.arc_weight = wt;
        w.list_position = lpos;
        return w;
    endfunction

    function automatic logic [9:0] rnd10();
        return 10'($urandom);
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(0, 15);
            2:       return $urandom_range(1, 4) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_words.size() > 0 || in_valid || expected_words.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mode(input bit mode);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= mode;
        weighted_q = mode;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // one node: begin, arcs from small pools so communities repeat, a few reads
    task automatic queue_node();
        logic [9:0]  node, base;
        logic [95:0] raw;
        int          arcs;
        node = rnd10();
        base = rnd10();
        arcs = $urandom_range(2, 14);
        enqueue(make_word(OP_BEGIN, node, rnd10(), base, $urandom, rnd10()));
        for (int k = 0; k < arcs; k++) begin
            if ($urandom_range(9) == 0)
                enqueue(make_word(OP_ARC, rnd10(), node, rnd10(), $urandom, rnd10()));
            else
                enqueue(make_word(OP_ARC, rnd10(), rnd10(),
                                  base + 10'($urandom_range(0, 6)), pick_weight(),
                                  rnd10()));
            if ($urandom_range(3) == 0)
                enqueue(make_word(OP_READ, rnd10(), rnd10(), rnd10(),
                                  $urandom, 10'($urandom_range(0, 8))));
        end
        if ($urandom_range(4) == 0)
            enqueue(make_word(OP_IDLE, rnd10(), rnd10(), rnd10(), $urandom, rnd10()));
        if ($urandom_range(6) == 0) begin
            raw = {$urandom, $urandom, $urandom};
            enqueue(raw[$bits(t_nca_in)-1:0]);
        end
    endtask

    task automatic queue_random(input int count);
        int start;
        start = pending_words.size();
        while (pending_words.size() - start < count) queue_node();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unweighted: arcs before any begin, self loops, reads in and out of range
        set_mode(1'b0);
        enqueue(make_word(OP_ARC, 10'd0, 10'd3, 10'd9, 32'hFFFF_FFFF, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd0, 10'd9, 32'h0, 10'd0));
        enqueue(make_word(OP_READ, 10'd0, 10'd0, 10'd0, 32'h0, 10'd0));
        enqueue(make_word(OP_BEGIN, 10'd5, 10'd0, 10'd7, 32'h0, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd5, 10'd12, 32'h5, 10'd0));
        enqueue(make_word(OP_ARC, 10'd1023, 10'd0, 10'd7, 32'h3, 10'd1023));
        enqueue(make_word(OP_ARC, 10'd0, 10'd1023, 10'd1023, 32'h0, 10'd0));
        enqueue(make_word(OP_READ, 10'd0, 10'd0, 10'd0, 32'h0, 10'd1));
        enqueue(make_word(OP_READ, 10'd0, 10'd0, 10'd0, 32'h0, 10'd2));
        enqueue(make_word(OP_READ, 10'd0, 10'd0, 10'd0, 32'h0, 10'd1023));
        enqueue(make_word(OP_IDLE, 10'd1023, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 10'd1023));
        wait_drained();

        // weighted: saturation, zero weight, a fresh node
        set_mode(1'b1);
        enqueue(make_word(OP_BEGIN, 10'd1023, 10'd0, 10'd0, 32'h0, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd1, 10'd1023, 32'hFFFF_FFFF, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd2, 10'd1023, 32'hFFFF_FFFF, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd3, 10'd0, 32'h0, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd4, 10'd0, 32'hFFFF_0001, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd5, 10'd0, 32'h0000_FFFF, 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd1023, 10'd512, 32'h1, 10'd0));
        enqueue(make_word(OP_READ, 10'd0, 10'd0, 10'd0, 32'h0, 10'd1));
        wait_drained();

        // full list: every community found once, then read the last slot and clear it
        calm = 1'b1;
        enqueue(make_word(OP_BEGIN, 10'd1000, 10'd0, 10'd0, 32'h0, 10'd0));
        for (int c = 1; c < COMM_SLOTS; c++)
            enqueue(make_word(OP_ARC, 10'd0, c[9:0] % 10'd999, c[9:0],
                              pick_weight(), 10'd0));
        enqueue(make_word(OP_ARC, 10'd0, 10'd1, 10'd700, 32'h7, 10'd0));
        enqueue(make_word(OP_READ, 10'd0, 10'd0, 10'd0, 32'h0, 10'd1023));
        enqueue(make_word(OP_BEGIN, 10'd2, 10'd0, 10'd3, 32'h0, 10'd0));
        wait_drained();
        calm = 1'b0;

        // random nodes, with a long receiver hold-off while words keep coming
        set_mode(1'b0);
        queue_random(250);
        repeat (40) @(posedge i_clk);
        hold_req = 1'b1;
        wait_drained();
        set_mode(1'b1);
        queue_random(250);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** neighbor_community_accumulator: PASSED **");
        end else begin
            $display("** neighbor_community_accumulator: FAILED **");
        end
        $finish;
    end
endmodule
